// File: hw/rtl/rpl_pkg.sv
// Shared constants, types and the division step function for the RGB555 palette blender.
package rpl_pkg;

	// Fixed-point weight precision: t runs from 0 to 2^WEIGHT_BITS
	localparam int WEIGHT_BITS = 12;

	// Field widths
	localparam int COLOR_W = 16;
	localparam int CH_W    = 5;
	localparam int NUM_CH  = 3;
	localparam int FLAG_BIT = COLOR_W - 1;
	localparam int IDX_W   = 8;
	localparam int CNT_W   = 9;

	// Stream data widths, padded to whole bytes
	localparam int S_DATA_W = ((2 * COLOR_W + IDX_W + 7) / 8) * 8;
	localparam int M_DATA_W = ((COLOR_W + 7) / 8) * 8;

	// Divider sizing: one quotient bit per step, quotient covers 0..2^WEIGHT_BITS
	localparam int QUO_W           = WEIGHT_BITS + 1;
	localparam int REM_W           = CNT_W;
	localparam int XW              = CNT_W + 1;
	localparam int DIV_STEPS       = QUO_W;
	localparam int DIV_STAGES      = 4;
	localparam int STEPS_PER_STAGE = (DIV_STEPS + DIV_STAGES - 1) / DIV_STAGES;

	// Blend arithmetic widths
	localparam int PROD_W = CH_W + QUO_W;
	localparam int SUM_W  = PROD_W + 1;

	localparam logic [QUO_W-1:0] FULL_WEIGHT      = {1'b1, {WEIGHT_BITS{1'b0}}};
	localparam logic [CNT_W-1:0] STEP_COUNT_RESET = CNT_W'(16);

	// Item payload that rides along the pipeline
	typedef struct packed {
		logic [COLOR_W-1:0] color_a;
		logic [COLOR_W-1:0] color_b;
		logic               clamped;
	} item_t;

	// Partial division state
	typedef struct packed {
		logic [REM_W-1:0] rem;
		logic [QUO_W-1:0] quot;
	} div_t;

	// Run one stage worth of restoring-division steps on (idx << WEIGHT_BITS) / divisor.
	// Step 0 brings in the index itself, later steps shift in zeros.
	function automatic div_t div_chunk(
		input div_t             acc,
		input logic [IDX_W-1:0] idx,
		input logic [CNT_W-1:0] divisor,
		input int               first
	);
		div_t           res;
		logic [XW-1:0]  x;
		logic [XW-1:0]  diff;
		logic           qb;
		int             s;
		res = acc;
		for (int j = 0; j < STEPS_PER_STAGE; j++) begin
			s = first + j;
			if (s < DIV_STEPS) begin
				x    = (s == 0) ? XW'(idx) : {res.rem, 1'b0};
				qb   = (x >= XW'(divisor));
				diff = x - XW'(divisor);
				res.rem  = qb ? diff[REM_W-1:0] : x[REM_W-1:0];
				res.quot = {res.quot[QUO_W-2:0], qb};
			end
		end
		return res;
	endfunction

endpackage

// File: hw/rtl/rgb555_palette_lerp_top.sv
// Top level of the RGB555 palette blender: stream ports, step count register, pipeline.
// The block blends two RGB555 colors (bit 15 a flag, red in the low bits) by the weight
// t = step_index*4096/step_count, ORs the flags and flags a zero step count or an index beyond it.
// It takes one transaction every cycle while the output is not held and passes it through
// four register stages of a restoring divider (up to four quotient bits each) and two
// blend stages (products, then sum and repack). Every stage has its own valid bit and
// loads whenever it is empty or draining, so input is taken while a finished result waits
// on m_tready as long as an earlier stage is free.
// step_count resets to 16 and should only be written while no transaction is in flight.
module rgb555_palette_lerp_top (
	input  logic                         clk,
	input  logic                         arst_n,
	// Input stream
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [rpl_pkg::S_DATA_W-1:0] s_tdata,  // color_a[15:0], color_b[31:16], step_index[39:32]
	// Output stream
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [rpl_pkg::M_DATA_W-1:0] m_tdata,  // blended_color[15:0]
	output logic                         m_tuser,  // index_clamped[0]
	// Step count register write
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [rpl_pkg::CNT_W-1:0]    cfg_data
);

	logic [rpl_pkg::CNT_W-1:0]   step_count_q;
	logic                        div_valid, div_ready;
	rpl_pkg::item_t              div_item;
	logic [rpl_pkg::QUO_W-1:0]   div_quot;
	logic [rpl_pkg::COLOR_W-1:0] blended_color;

	// Step count register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_count_q <= rpl_pkg::STEP_COUNT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			step_count_q <= cfg_data;
		end
	end

	// Weight division
	rpl_div u_div (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.color_a    (s_tdata[rpl_pkg::COLOR_W-1:0]),
		.color_b    (s_tdata[2*rpl_pkg::COLOR_W-1:rpl_pkg::COLOR_W]),
		.step_index (s_tdata[2*rpl_pkg::COLOR_W +: rpl_pkg::IDX_W]),
		.step_count (step_count_q),
		.out_valid  (div_valid),
		.out_ready  (div_ready),
		.out_item   (div_item),
		.out_quot   (div_quot)
	);

	// Channel blend and output register
	rpl_mix u_mix (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (div_valid),
		.in_ready      (div_ready),
		.in_item       (div_item),
		.in_quot       (div_quot),
		.out_valid     (m_tvalid),
		.out_ready     (m_tready),
		.blended_color (blended_color),
		.index_clamped (m_tuser)
	);

	assign m_tdata = rpl_pkg::M_DATA_W'(blended_color);

`ifndef ASSERT_OFF
	// An unclamped quotient never exceeds full scale
	assert property (@(posedge clk) disable iff (!arst_n)
		div_valid && !div_item.clamped |-> div_quot <= rpl_pkg::FULL_WEIGHT)
		else $error("weight quotient above full scale");

	// Input stalls only when every stage is full and the output is held
	assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready && div_valid)
		else $error("input stalled with a free pipeline stage");

	// A register write lands on the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready |=> step_count_q == $past(cfg_data))
		else $error("step count write lost");
`endif

endmodule

// File: hw/rtl/rpl_div.sv
// Four-stage pipelined divider producing the blend weight index*2^W/step_count.
module rpl_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [rpl_pkg::COLOR_W-1:0] color_a,
	input  logic [rpl_pkg::COLOR_W-1:0] color_b,
	input  logic [rpl_pkg::IDX_W-1:0]   step_index,
	input  logic [rpl_pkg::CNT_W-1:0]   step_count,
	output logic                        out_valid,
	input  logic                        out_ready,
	output rpl_pkg::item_t              out_item,
	output logic [rpl_pkg::QUO_W-1:0]   out_quot
);

	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4;
	rpl_pkg::item_t item_s1, item_s2, item_s3, item_s4;
	rpl_pkg::div_t  acc_s1, acc_s2, acc_s3, acc_s4;
	rpl_pkg::item_t item_in;

	// Per-stage ready: a stage loads when empty or when its content moves on
	assign rdy_s4   = !v_s4 || out_ready;
	assign rdy_s3   = !v_s3 || rdy_s4;
	assign rdy_s2   = !v_s2 || rdy_s3;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	// Clamp when the count is zero or the index lies beyond it
	always_comb begin
		item_in.color_a = color_a;
		item_in.color_b = color_b;
		item_in.clamped = (step_count == '0) ||
			({1'b0, step_index} > step_count);
	end

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= in_valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
		end
	end

	// Payload and division steps
	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			item_s1 <= item_in;
			acc_s1  <= rpl_pkg::div_chunk('0, step_index, step_count, 0);
		end
		if (rdy_s2 && v_s1) begin
			item_s2 <= item_s1;
			acc_s2  <= rpl_pkg::div_chunk(acc_s1, '0, step_count,
				rpl_pkg::STEPS_PER_STAGE);
		end
		if (rdy_s3 && v_s2) begin
			item_s3 <= item_s2;
			acc_s3  <= rpl_pkg::div_chunk(acc_s2, '0, step_count,
				2 * rpl_pkg::STEPS_PER_STAGE);
		end
		if (rdy_s4 && v_s3) begin
			item_s4 <= item_s3;
			acc_s4  <= rpl_pkg::div_chunk(acc_s3, '0, step_count,
				3 * rpl_pkg::STEPS_PER_STAGE);
		end
	end

	assign out_valid = v_s4;
	assign out_item  = item_s4;
	assign out_quot  = acc_s4.quot;

endmodule

// File: hw/rtl/rpl_mix.sv
// Two-stage channel blend: weighted products, then sum, shift and repack.
module rpl_mix (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  rpl_pkg::item_t              in_item,
	input  logic [rpl_pkg::QUO_W-1:0]   in_quot,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [rpl_pkg::COLOR_W-1:0] blended_color,
	output logic                        index_clamped
);

	logic v_s5, v_s6;
	logic rdy_s5, rdy_s6;
	logic [rpl_pkg::QUO_W-1:0]  weight;
	logic [rpl_pkg::QUO_W-1:0]  inv_weight;
	logic [rpl_pkg::PROD_W-1:0] pa [rpl_pkg::NUM_CH];
	logic [rpl_pkg::PROD_W-1:0] pb [rpl_pkg::NUM_CH];
	logic [rpl_pkg::PROD_W-1:0] pa_s5 [rpl_pkg::NUM_CH];
	logic [rpl_pkg::PROD_W-1:0] pb_s5 [rpl_pkg::NUM_CH];
	logic                       flag_s5, clamp_s5;
	logic [rpl_pkg::SUM_W-1:0]  sum [rpl_pkg::NUM_CH];
	logic [rpl_pkg::COLOR_W-1:0] color_next;
	logic [rpl_pkg::COLOR_W-1:0] color_s6;
	logic                        clamp_s6;

	assign rdy_s6   = !v_s6 || out_ready;
	assign rdy_s5   = !v_s5 || rdy_s6;
	assign in_ready = rdy_s5;

	// Weight select and per-channel products
	always_comb begin
		weight     = in_item.clamped ? rpl_pkg::FULL_WEIGHT : in_quot;
		inv_weight = rpl_pkg::FULL_WEIGHT - weight;
		for (int c = 0; c < rpl_pkg::NUM_CH; c++) begin
			pa[c] = rpl_pkg::PROD_W'(in_item.color_a[c*rpl_pkg::CH_W +: rpl_pkg::CH_W]) *
				rpl_pkg::PROD_W'(inv_weight);
			pb[c] = rpl_pkg::PROD_W'(in_item.color_b[c*rpl_pkg::CH_W +: rpl_pkg::CH_W]) *
				rpl_pkg::PROD_W'(weight);
		end
	end

	// Sum, drop the fraction, repack with ORed flag
	always_comb begin
		color_next = '0;
		for (int c = 0; c < rpl_pkg::NUM_CH; c++) begin
			sum[c] = rpl_pkg::SUM_W'(pa_s5[c]) + rpl_pkg::SUM_W'(pb_s5[c]);
			color_next[c*rpl_pkg::CH_W +: rpl_pkg::CH_W] =
				sum[c][rpl_pkg::WEIGHT_BITS +: rpl_pkg::CH_W];
		end
		color_next[rpl_pkg::FLAG_BIT] = flag_s5;
	end

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (rdy_s5) v_s5 <= in_valid;
			if (rdy_s6) v_s6 <= v_s5;
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (rdy_s5 && in_valid) begin
			pa_s5    <= pa;
			pb_s5    <= pb;
			flag_s5  <= in_item.color_a[rpl_pkg::FLAG_BIT] |
				in_item.color_b[rpl_pkg::FLAG_BIT];
			clamp_s5 <= in_item.clamped;
		end
		if (rdy_s6 && v_s5) begin
			color_s6 <= color_next;
			clamp_s6 <= clamp_s5;
		end
	end

	assign out_valid     = v_s6;
	assign blended_color = color_s6;
	assign index_clamped = clamp_s6;

endmodule

// File: dv/testbench.sv
// Self-checking testbench for the RGB555 palette blender: stream traffic, step count writes.
`timescale 1ns / 1ps

module testbench;

	localparam int CYCLE_LIMIT  = 300000;
	localparam int SEG_ITEMS    = 242;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 20;

	// One blended result as it leaves the block
	typedef struct packed {
		logic [rpl_pkg::COLOR_W-1:0] color;
		logic                        clamped;
	} blend_t;

	// Scoreboard: predicts each blend on input acceptance, checks results in order
	class blend_checker;
		logic [rpl_pkg::CNT_W-1:0] step_count;
		blend_t                    expected_blends[$];
		int                        fail_count;

		function new();
			step_count = rpl_pkg::STEP_COUNT_RESET;
			fail_count = 0;
		endfunction

		function blend_t predict_blend(logic [rpl_pkg::COLOR_W-1:0] ca,
				logic [rpl_pkg::COLOR_W-1:0] cb, logic [rpl_pkg::IDX_W-1:0] idx);
			blend_t      r;
			int unsigned full;
			int unsigned wt;
			int unsigned pa;
			int unsigned pb;
			full = 1 << rpl_pkg::WEIGHT_BITS;
			// zero step count or an index past the end saturates the weight
			if (step_count == 0 || idx > step_count) begin
				wt        = full;
				r.clamped = 1'b1;
			end else begin
				wt        = (idx * full) / step_count;
				r.clamped = 1'b0;
			end
			r.color = '0;
			for (int c = 0; c < rpl_pkg::NUM_CH; c++) begin
				pa = ca[c*rpl_pkg::CH_W +: rpl_pkg::CH_W];
				pb = cb[c*rpl_pkg::CH_W +: rpl_pkg::CH_W];
				r.color[c*rpl_pkg::CH_W +: rpl_pkg::CH_W] =
					rpl_pkg::CH_W'((pa * (full - wt) + pb * wt) >> rpl_pkg::WEIGHT_BITS);
			end
			r.color[rpl_pkg::FLAG_BIT] = ca[rpl_pkg::FLAG_BIT] | cb[rpl_pkg::FLAG_BIT];
			return r;
		endfunction

		function void note_input(logic [rpl_pkg::COLOR_W-1:0] ca,
				logic [rpl_pkg::COLOR_W-1:0] cb, logic [rpl_pkg::IDX_W-1:0] idx);
			expected_blends.push_back(predict_blend(ca, cb, idx));
		endfunction

		task report_mismatch(string what, logic [rpl_pkg::COLOR_W-1:0] got,
				logic [rpl_pkg::COLOR_W-1:0] want);
			$display("[%0t] mismatch: %s got %h want %h", $realtime, what, got, want);
			fail_count++;
		endtask

		task check_result(logic [rpl_pkg::COLOR_W-1:0] color, logic clamped);
			blend_t want;
			if (expected_blends.size() == 0) begin
				report_mismatch("result with nothing pending", color, '0);
			end else begin
				want = expected_blends.pop_front();
				if (color !== want.color)
					report_mismatch("blended_color", color, want.color);
				if (clamped !== want.clamped)
					report_mismatch("index_clamped", rpl_pkg::COLOR_W'(clamped),
						rpl_pkg::COLOR_W'(want.clamped));
			end
		endtask
	endclass

	logic                         clk;
	logic                         arst_n;
	logic                         s_tvalid;
	logic                         s_tready;
	logic [rpl_pkg::S_DATA_W-1:0] s_tdata;
	logic                         m_tvalid;
	logic                         m_tready;
	logic [rpl_pkg::M_DATA_W-1:0] m_tdata;
	logic                         m_tuser;
	logic                         cfg_valid;
	logic                         cfg_ready;
	logic [rpl_pkg::CNT_W-1:0]    cfg_data;

	blend_checker board;
	int           send_idle_pct;
	int           recv_idle_pct;
	bit           hold_req;
	int           cycle_count;

	rgb555_palette_lerp_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	// 10 ns clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Run limit
	initial cycle_count = 0;
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// Offer one color pair, with random idle cycles ahead of it
	task automatic send_item(input logic [rpl_pkg::COLOR_W-1:0] ca,
			input logic [rpl_pkg::COLOR_W-1:0] cb, input logic [rpl_pkg::IDX_W-1:0] idx);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= rpl_pkg::S_DATA_W'({idx, cb, ca});
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		board.note_input(ca, cb, idx);
	endtask

	// Step count write, only once the pipeline has drained
	task automatic write_step_count(input logic [rpl_pkg::CNT_W-1:0] value);
		s_tvalid <= 1'b0;
		while (board.expected_blends.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		board.step_count = value;
	endtask

	function automatic logic [rpl_pkg::COLOR_W-1:0] pick_corner();
		case ($urandom_range(3))
			0:       return 16'h0000;
			1:       return 16'h7FFF;
			2:       return 16'h8000;
			default: return 16'hFFFF;
		endcase
	endfunction

	function automatic logic [rpl_pkg::COLOR_W-1:0] pick_color();
		case ($urandom_range(7))
			0:       return pick_corner();
			default: return rpl_pkg::COLOR_W'($urandom_range(0, 65535));
		endcase
	endfunction

	// Index mostly near or inside the fade range, sometimes right at its edges
	function automatic logic [rpl_pkg::IDX_W-1:0] pick_index(input int sc);
		int top;
		top = (sc > 255) ? 255 : sc;
		case ($urandom_range(9))
			0, 1, 2, 3: return rpl_pkg::IDX_W'($urandom_range(0, 255));
			4, 5, 6:    return rpl_pkg::IDX_W'($urandom_range(0, top));
			7:          return rpl_pkg::IDX_W'(top);
			8:          return rpl_pkg::IDX_W'((sc + 1 > 255) ? 255 : sc + 1);
			default:    return ($urandom_range(1) != 0) ? rpl_pkg::IDX_W'(255) :
				rpl_pkg::IDX_W'(0);
		endcase
	endfunction

	// Result side: random backpressure plus one long hold on request
	initial begin
		int hold_left;
		hold_left = 0;
		m_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready)
				board.check_result(m_tdata[rpl_pkg::COLOR_W-1:0], m_tuser);
			if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// Stimulus
	initial begin
		int sc;
		board         = new();
		send_idle_pct = 29;
		recv_idle_pct = 85;
		hold_req      = 1'b0;
		arst_n    <= 1'b0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		cfg_valid <= 1'b0;
		cfg_data  <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset step count of 16: range start, exact end, just past the end, far past
		send_item(16'h0000, 16'hFFFF, 8'd0);
		send_item(16'h0000, 16'hFFFF, 8'd16);
		send_item(16'hFFFF, 16'h0000, 8'd8);
		send_item(16'h7FFF, 16'h8000, 8'd17);
		send_item(16'h1234, 16'h5678, 8'd255);
		send_item(16'hFFFF, 16'hFFFF, 8'd15);
		send_item(16'h7C1F, 16'h03E0, 8'd4);
		// zero step count: every index clamps
		write_step_count(9'd0);
		send_item(16'h0000, 16'h7FFF, 8'd0);
		send_item(16'h8000, 16'h0000, 8'd255);
		send_item(16'h7FFF, 16'h0000, 8'd1);
		// step count beyond the nominal range
		write_step_count(9'd511);
		send_item(16'h0000, 16'h7FFF, 8'd255);
		send_item(16'h7FFF, 16'h0000, 8'd128);
		send_item(16'hFFFF, 16'h0000, 8'd1);
		// single step
		write_step_count(9'd1);
		send_item(16'h0000, 16'h7FFF, 8'd0);
		send_item(16'h0000, 16'h7FFF, 8'd1);
		send_item(16'h7FFF, 16'h0000, 8'd2);
		// largest nominal count, index can never pass it
		write_step_count(9'd256);
		send_item(16'h0000, 16'h7FFF, 8'd255);
		send_item(16'h7FFF, 16'h0000, 8'd128);
		write_step_count(9'd255);
		send_item(16'h0000, 16'h7FFF, 8'd255);
		send_item(16'hFFFF, 16'h0000, 8'd254);

		// random segments, each with its own step count; idling changes every two
		for (int seg = 0; seg < 6; seg++) begin
			case (seg)
				0:       sc = 256;
				1:       sc = $urandom_range(2, 255);
				2:       sc = 1;
				3:       sc = 511;
				4:       sc = 0;
				default: sc = $urandom_range(0, 511);
			endcase
			write_step_count(rpl_pkg::CNT_W'(sc));
			case (seg / 2)
				0: begin
					send_idle_pct = 29;
					recv_idle_pct = 85;
				end
				1: begin
					send_idle_pct = 85;
					recv_idle_pct = 29;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			// long output stall while input keeps coming, to fill the pipeline
			if (seg == 1 || seg == 4)
				hold_req = 1'b1;
			for (int n = 0; n < SEG_ITEMS; n++)
				send_item(pick_color(), pick_color(), pick_index(sc));
		end

		s_tvalid <= 1'b0;
		while (board.expected_blends.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (board.fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
